// File: rtl/npc_pkg.sv
// Shared widths, codes and helpers for the nearest palette colour search.
package npc_pkg;

  localparam int COLOR_W      = 24;
  localparam int CH_W         = 8;
  localparam int IDX_IN_W     = 5;
  localparam int CFG_W        = 6;
  localparam int SQ_OP_W      = CH_W + 1;
  localparam int SQ_W         = 2 * SQ_OP_W;
  localparam int SQRT_TOP_BIT = SQ_OP_W - 1;
  localparam int BIT_W        = 4;
  localparam int RED_SHIFT    = 16;
  localparam int GREEN_SHIFT  = 8;

  localparam int NPC_DEPTH_DEFAULT = 32;

  localparam logic [CFG_W-1:0] CNT_RESET = CFG_W'(1);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CH_W-1:0]    chan_t;

  function automatic chan_t chan_absdiff(input chan_t a, input chan_t b);
    chan_t d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

// File: rtl/npc_in_if.sv
// Input channel: palette write or colour query transfer.
interface npc_in_if import npc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                func;
  logic [IDX_IN_W-1:0] entry_index;
  color_t              color;

  modport source (output valid, func, entry_index, color, input ready);
  modport sink   (input valid, func, entry_index, color, output ready);
endinterface

// File: rtl/npc_out_if.sv
// Result channel: nearest palette colour and exact-match flag.
interface npc_out_if import npc_pkg::*;;
  logic   valid;
  logic   ready;
  color_t closest_color;
  logic   exact_match;

  modport source (output valid, closest_color, exact_match, input ready);
  modport sink   (input valid, closest_color, exact_match, output ready);
endinterface

// File: rtl/nearest_palette_color.sv
// Nearest palette colour search. A write transfer (func 0) stores one 24-bit
// RGB entry. A query transfer (func 1) walks entries 0 .. palette_count-1
// (0 reads as 1, values above the depth clip to it) through one shared 9x9
// squarer: each entry passes read, three channel squares, compare and advance,
// plus a bit-by-bit square root when it becomes the new best. Entry 0 is
// always the first best, and an exact match stops the walk early. The input
// is not ready while a query is in flight or its result awaits transfer.
// palette_count is to be written by the user only while idle; the block
// itself does not enforce it.
module nearest_palette_color import npc_pkg::*; #(
  parameter int PALETTE_DEPTH = NPC_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  npc_in_if.sink           in_ch,
  npc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(PALETTE_DEPTH + 1);
  localparam int CNT_W   = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_RED  = 4'd2;
  localparam logic [3:0] S_GRN  = 4'd3;
  localparam logic [3:0] S_BLU  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               first_r, first_nxt;
  color_t             query_r, query_nxt;
  color_t             best_r, best_nxt;
  logic [SQ_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]    thr_r, thr_nxt;
  logic [SQ_OP_W-1:0] root_r, root_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;

  logic [CNT_W-1:0]   cnt_ext, cnt_eff;
  logic               in_xfer, mem_we, slot_ok;
  color_t             rdata;
  logic [SQ_OP_W-1:0] sq_op, cand;
  logic [SQ_W-1:0]    sq;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign slot_ok = CNT_W'(in_ch.entry_index) < CNT_W'(PALETTE_DEPTH);
  assign mem_we  = in_xfer && (in_ch.func == FUNC_WRITE) && slot_ok;

  always_comb begin
    cnt_ext = CNT_W'(cnt_r);
    if (cnt_ext == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_ext > CNT_W'(PALETTE_DEPTH)) begin
      cnt_eff = CNT_W'(PALETTE_DEPTH);
    end else begin
      cnt_eff = cnt_ext;
    end
  end

  npc_palette_mem #(
    .DEPTH (PALETTE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IDX_W'(in_ch.entry_index)),
    .wdata (in_ch.color),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Trial root for the current square-root bit
  assign cand = root_r | (SQ_OP_W'(1) << bit_r);

  always_comb begin
    case (state_r)
      S_RED:   sq_op = SQ_OP_W'(chan_absdiff(query_r[RED_SHIFT +: CH_W],
                                             rdata[RED_SHIFT +: CH_W]));
      S_GRN:   sq_op = SQ_OP_W'(chan_absdiff(query_r[GREEN_SHIFT +: CH_W],
                                             rdata[GREEN_SHIFT +: CH_W]));
      S_BLU:   sq_op = SQ_OP_W'(chan_absdiff(query_r[CH_W-1:0], rdata[CH_W-1:0]));
      S_SQRT:  sq_op = cand;
      default: sq_op = '0;
    endcase
  end

  npc_squarer u_sq (
    .op (sq_op),
    .sq (sq)
  );

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    first_nxt = first_r;
    query_nxt = query_r;
    best_nxt  = best_r;
    sum_nxt   = sum_r;
    thr_nxt   = thr_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.func == FUNC_QUERY)) begin
          ptr_nxt   = '0;
          first_nxt = 1'b1;
          query_nxt = in_ch.color;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_RED;
      S_RED: begin
        sum_nxt   = sq;
        state_nxt = S_GRN;
      end
      S_GRN: begin
        sum_nxt   = sum_r + sq;
        state_nxt = S_BLU;
      end
      S_BLU: begin
        sum_nxt   = sum_r + sq;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // thr holds the square of the best truncated root: sum < thr is
        // the same as a strictly smaller truncated root
        if (first_r || (sum_r < thr_r)) begin
          best_nxt  = rdata;
          first_nxt = 1'b0;
          root_nxt  = '0;
          thr_nxt   = '0;
          bit_nxt   = BIT_W'(SQRT_TOP_BIT);
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SQRT: begin
        if (sq <= sum_r) begin
          root_nxt = cand;
          thr_nxt  = sq;
        end
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if ((thr_r == '0) || ((ptr_r + CNT_W'(1)) == cnt_eff)) begin
          state_nxt = S_OUT;
        end else begin
          ptr_nxt   = ptr_r + CNT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= CNT_RESET;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    query_r <= query_nxt;
    best_r  <= best_nxt;
    sum_r   <= sum_nxt;
    thr_r   <= thr_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = (state_r == S_OUT);
  assign out_ch.closest_color = best_r;
  assign out_ch.exact_match   = (thr_r == '0);

endmodule

// File: rtl/npc_palette_mem.sv
// Palette table: one write port, one registered read port.
module npc_palette_mem import npc_pkg::*; #(
  parameter int DEPTH = NPC_DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  color_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output color_t           rdata
);

  color_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/npc_squarer.sv
// Shared squarer for channel differences and square-root trial roots.
module npc_squarer import npc_pkg::*; (
  input  logic [SQ_OP_W-1:0] op,
  output logic [SQ_W-1:0]    sq
);

  assign sq = SQ_W'(op) * SQ_W'(op);

endmodule

// File: tb/sv/nearest_palette_color_tb.sv
// Testbench for the nearest palette colour search: random traffic, scoreboard check.
`timescale 1ns / 1ps

module nearest_palette_color_tb;
  import npc_pkg::*;

  localparam int DEPTH      = NPC_DEPTH_DEFAULT;
  localparam int RAND_ITEMS = 2000;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 32;
  localparam int WD_LIMIT   = 10000;

  typedef struct {
    logic                func;
    logic [IDX_IN_W-1:0] entry_index;
    color_t              color;
  } palette_item_t;

  typedef struct {
    color_t color;
    logic   exact;
  } nearest_t;

  class palette_match_board;
    color_t      pal_copy[DEPTH];
    int unsigned search_len;
    nearest_t    nearest_q[$];
    int unsigned errors;

    function new();
      foreach (pal_copy[i]) pal_copy[i] = '0;
      search_len = CNT_RESET;
      errors     = 0;
    endfunction

    function void set_search_len(int unsigned n);
      search_len = n;
    endfunction

    function int unsigned pending();
      return nearest_q.size();
    endfunction

    static function int unsigned isqrt(int unsigned v);
      int unsigned r;
      r = 0;
      for (int b = 9; b >= 0; b--)
        if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
      return r;
    endfunction

    static function int unsigned rgb_dist(color_t e, color_t q);
      int dr, dg, db;
      dr = int'(e[RED_SHIFT +: CH_W]) - int'(q[RED_SHIFT +: CH_W]);
      dg = int'(e[GREEN_SHIFT +: CH_W]) - int'(q[GREEN_SHIFT +: CH_W]);
      db = int'(e[0 +: CH_W]) - int'(q[0 +: CH_W]);
      return isqrt(dr * dr + dg * dg + db * db);
    endfunction

    // First entry with the strictly lowest truncated distance wins.
    function nearest_t nearest_entry(color_t q);
      nearest_t    res;
      int unsigned best, s;
      res.color = pal_copy[0];
      best      = rgb_dist(pal_copy[0], q);
      for (int i = 1; i < search_len && best != 0; i++) begin
        s = rgb_dist(pal_copy[i], q);
        if (s < best) begin
          best      = s;
          res.color = pal_copy[i];
        end
      end
      res.exact = (best == 0);
      return res;
    endfunction

    function void note_transfer(palette_item_t it);
      if (it.func == FUNC_WRITE) begin
        if (it.entry_index < DEPTH) pal_copy[it.entry_index] = it.color;
      end else begin
        nearest_q.push_back(nearest_entry(it.color));
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(color_t got_color, logic got_exact);
      nearest_t exp;
      if (nearest_q.size() == 0) begin
        report($sformatf("result %06h with no query outstanding", got_color));
      end else begin
        exp = nearest_q.pop_front();
        if (got_color !== exp.color)
          report($sformatf("closest_color %06h, expected %06h", got_color, exp.color));
        if (got_exact !== exp.exact)
          report($sformatf("exact_match %b, expected %b", got_exact, exp.exact));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  npc_in_if  in_ch();
  npc_out_if out_ch();

  nearest_palette_color dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  palette_match_board board;
  palette_item_t      stim_q[$];
  logic               offering;
  logic               hold_req;
  logic               loaded[DEPTH];
  color_t             gen_pal[DEPTH];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic int unsigned clip_count(int unsigned v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return chan_t'($urandom);
    endcase
  endfunction

  task push_item(logic func, int unsigned idx, color_t color);
    palette_item_t it;
    it.func        = func;
    it.entry_index = IDX_IN_W'(idx);
    it.color       = color;
    if (func == FUNC_WRITE) begin
      loaded[idx]  = 1'b1;
      gen_pal[idx] = color;
    end
    stim_q.push_back(it);
  endtask

  // Slots inside the searched range are loaded before any query reaches them.
  task push_random(int unsigned n);
    int unsigned hole, slot, r;
    color_t      c;
    hole = DEPTH;
    for (int i = n - 1; i >= 0; i--)
      if (!loaded[i]) hole = i;
    if (hole < DEPTH) begin
      push_item(FUNC_WRITE, hole, {rand_chan(), rand_chan(), rand_chan()});
    end else if ($urandom_range(0, 99) < 35) begin
      slot = $urandom_range(0, DEPTH - 1);
      if ($urandom_range(0, 1)) c = color_t'($urandom);
      else c = {rand_chan(), rand_chan(), rand_chan()};
      push_item(FUNC_WRITE, slot, c);
    end else begin
      r    = $urandom_range(0, 9);
      slot = $urandom_range(0, n - 1);
      if (r < 4) c = color_t'($urandom);
      else if (r < 6) c = gen_pal[slot];
      else if (r < 9) c = gen_pal[slot] ^ (color_t'($urandom) & 24'h0F0F0F);
      else c = {rand_chan(), rand_chan(), rand_chan()};
      // the index field is ignored on queries, so it is left random
      push_item(FUNC_QUERY, $urandom_range(0, DEPTH - 1), c);
    end
  endtask

  task wait_drained();
    while (stim_q.size() != 0 || offering || board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_count(logic [CFG_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    board.set_search_len(clip_count(v));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sender: one transfer per item, random gap before each.
  initial begin
    palette_item_t cur;
    int unsigned   gap, calm;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_WRITE;
    in_ch.entry_index = '0;
    in_ch.color       = '0;
    offering          = 1'b0;
    gap               = 0;
    calm              = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        board.note_transfer(cur);
        offering = 1'b0;
        gap      = draw_gap(calm);
      end
      @(negedge clk);
      if (!offering) begin
        if (gap > 0) begin
          gap--;
        end else if (stim_q.size() != 0) begin
          cur               = stim_q.pop_front();
          in_ch.func        = cur.func;
          in_ch.entry_index = cur.entry_index;
          in_ch.color       = cur.color;
          offering          = 1'b1;
        end
      end
      in_ch.valid = offering;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall, calm, hold_left;
    out_ch.ready = 1'b0;
    stall        = 0;
    calm         = 0;
    hold_left    = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.closest_color, out_ch.exact_match);
        stall = draw_gap(calm);
      end
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WD_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned done, phase, n, len;
    logic [CFG_W-1:0] v;
    board    = new();
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    foreach (loaded[i]) begin
      loaded[i]  = 1'b0;
      gen_pal[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset count searches entry 0 only
    push_item(FUNC_WRITE, 0, 24'h000000);
    push_item(FUNC_QUERY, 0, 24'h000000);
    push_item(FUNC_QUERY, 31, 24'hFFFFFF);
    push_item(FUNC_QUERY, 0, 24'h123456);
    push_item(FUNC_WRITE, 31, 24'hFFFFFF);

    // zero count behaves as one
    write_count(6'd0);
    push_item(FUNC_QUERY, 0, 24'hFFFFFF);
    push_item(FUNC_QUERY, 0, 24'h000000);

    // truncated tie keeps the lower slot; exact hit on the second slot
    write_count(6'd2);
    push_item(FUNC_WRITE, 1, 24'h000102);
    push_item(FUNC_QUERY, 0, 24'h000101);
    push_item(FUNC_QUERY, 0, 24'h000102);
    push_item(FUNC_QUERY, 0, 24'hFF0000);
    push_item(FUNC_QUERY, 0, 24'h00FF00);
    push_item(FUNC_QUERY, 0, 24'h0000FF);

    done  = 0;
    phase = 0;
    while (done < RAND_ITEMS) begin
      case (phase)
        0: v = 6'd63;
        1: v = 6'd32;
        default: begin
          case ($urandom_range(0, 9))
            6: v = 6'd0;
            7: v = 6'd32;
            8: v = 6'd63;
            9: v = CFG_W'($urandom_range(7, 31));
            default: v = CFG_W'($urandom_range(1, 6));
          endcase
        end
      endcase
      write_count(v);
      n   = clip_count(v);
      len = $urandom_range(80, 200);
      for (int i = 0; i < len; i++) push_random(n);
      done += len;
      if (phase == 2) begin
        // sink stalls while items keep coming, so the block backs up
        repeat (40) @(posedge clk);
        hold_req = 1'b1;
      end
      phase++;
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
